// ===== design/vsc_pkg.sv =====
// shared types, constants and action-list helpers for the voice session controller
`timescale 1ns / 1ps

package vsc_pkg;

  // widths and sizes
  localparam int TIME_BITS   = 32;
  localparam int MAX_ACTIONS = 4;
  localparam int CNT_W       = $clog2(MAX_ACTIONS + 1);
  localparam int IDX_W       = $clog2(MAX_ACTIONS);
  localparam int MODE_W      = 5;
  localparam int SIL_W       = 24;
  localparam int CFG_W       = 24;
  localparam int NUM_REGS    = 8;
  localparam int REG_SEL_W   = $clog2(NUM_REGS);
  localparam int CFG_IDX_W   = REG_SEL_W + 1;
  localparam int ACT_W       = 4;
  localparam int SS_W        = 3;

  // input tdata layout, lowest bit up: now_ms, heard_speech, silence_ms, ok, empty_req
  localparam int IN_HEARD_B  = TIME_BITS;
  localparam int IN_SIL_LO   = TIME_BITS + 1;
  localparam int IN_OK_B     = IN_SIL_LO + SIL_W;
  localparam int IN_EMPTY_B  = IN_OK_B + 1;
  localparam int IN_DATA_W   = ((IN_EMPTY_B + 1 + 7) / 8) * 8;

  // output tdata layout: eyes, speech, attach, accepted, session_state
  localparam int OUT_USED_W  = 2 + 3 + 1 + 1 + SS_W;
  localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;

  // register indexes
  localparam logic [REG_SEL_W-1:0] REG_MAX_LISTEN   = REG_SEL_W'(0);
  localparam logic [REG_SEL_W-1:0] REG_TRAIL_SIL    = REG_SEL_W'(1);
  localparam logic [REG_SEL_W-1:0] REG_NO_SPEECH    = REG_SEL_W'(2);
  localparam logic [REG_SEL_W-1:0] REG_ASR_START    = REG_SEL_W'(3);
  localparam logic [REG_SEL_W-1:0] REG_ASR_FINISH   = REG_SEL_W'(4);
  localparam logic [REG_SEL_W-1:0] REG_THINK        = REG_SEL_W'(5);
  localparam logic [REG_SEL_W-1:0] REG_APPROVAL     = REG_SEL_W'(6);
  localparam logic [REG_SEL_W-1:0] REG_SPEAK        = REG_SEL_W'(7);

  typedef logic [NUM_REGS-1:0][CFG_W-1:0] cfg_t;

  // register reset values, highest index first
  localparam cfg_t CFG_RST = {
    24'd180000, 24'd600000, 24'd120000, 24'd6000,
    24'd90000,  24'd5000,   24'd1600,   24'd8000
  };

  // reported session state codes
  localparam logic [SS_W-1:0] SS_OFF    = 3'd0;
  localparam logic [SS_W-1:0] SS_IDLE   = 3'd1;
  localparam logic [SS_W-1:0] SS_LISTEN = 3'd2;
  localparam logic [SS_W-1:0] SS_THINK  = 3'd3;
  localparam logic [SS_W-1:0] SS_SPEAK  = 3'd4;

  typedef enum logic [MODE_W-1:0] {
    EV_DISABLE      = 5'd0,
    EV_ENABLE       = 5'd1,
    EV_CANCEL       = 5'd2,
    EV_WAKE         = 5'd3,
    EV_LISTEN       = 5'd4,
    EV_SAY          = 5'd5,
    EV_ASR_STARTED  = 5'd6,
    EV_ASR_FAILED   = 5'd7,
    EV_ASR_ENDPOINT = 5'd8,
    EV_ASR_FINISHED = 5'd9,
    EV_REPLY        = 5'd10,
    EV_PENDING      = 5'd11,
    EV_BUSY         = 5'd12,
    EV_AGENT_FAILED = 5'd13,
    EV_SPEAK_DONE   = 5'd14,
    EV_LINK_LOST    = 5'd15,
    EV_TICK         = 5'd16
  } ev_t;

  typedef enum logic [ACT_W-1:0] {
    A_NONE         = 4'd0,
    A_EYES         = 4'd1,
    A_ASR_START    = 4'd2,
    A_ASR_CANCEL   = 4'd3,
    A_ASR_END      = 4'd4,
    A_SUBMIT       = 4'd5,
    A_AGENT_CANCEL = 4'd6,
    A_FORGET       = 4'd7,
    A_SPEAK        = 4'd8,
    A_SPEAK_CANCEL = 4'd9
  } act_code_t;

  typedef enum logic [1:0] {
    EYES_LISTEN  = 2'd0,
    EYES_SPEAK   = 2'd1,
    EYES_THINK   = 2'd2,
    EYES_RESTORE = 2'd3
  } eyes_t;

  typedef enum logic [2:0] {
    SP_REPLY     = 3'd0,
    SP_TEXT      = 3'd1,
    SP_APPROVAL  = 3'd2,
    SP_ERROR     = 3'd3,
    SP_NOT_HEARD = 3'd4,
    SP_BUSY      = 3'd5
  } speech_t;

  // session state machine, one-hot
  typedef enum logic [4:0] {
    ST_OFF    = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_LISTEN = 5'b00100,
    ST_THINK  = 5'b01000,
    ST_SPEAK  = 5'b10000
  } st_t;

  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic [TIME_BITS-1:0] now_ms;
    logic                 heard_speech;
    logic [SIL_W-1:0]     silence_ms;
    logic                 ok;
    logic                 empty_req;
  } evt_t;

  typedef struct packed {
    act_code_t action;
    eyes_t     eyes;
    speech_t   speech;
    logic      attach;
  } act_t;

  typedef struct packed {
    act_t [MAX_ACTIONS-1:0] item;
    logic [CNT_W-1:0]       cnt;
  } lst_t;

  typedef struct packed {
    st_t                  mode;
    logic [TIME_BITS-1:0] entered;
    logic [TIME_BITS-1:0] end_sent;
    logic [TIME_BITS-1:0] pend_since;
    logic                 started;
    logic                 end_req;
    logic                 appr;
  } sess_t;

  // session plus action list while an event is being worked out
  typedef struct packed {
    sess_t s;
    lst_t  l;
  } work_t;

  // what one event leaves for the output stage
  typedef struct packed {
    lst_t             lst;
    logic             accepted;
    logic [SS_W-1:0]  ss;
  } res_t;

  function automatic logic [SS_W-1:0] st_code(st_t st);
    logic [SS_W-1:0] c;
    case (st)
      ST_OFF:    c = SS_OFF;
      ST_IDLE:   c = SS_IDLE;
      ST_LISTEN: c = SS_LISTEN;
      ST_THINK:  c = SS_THINK;
      ST_SPEAK:  c = SS_SPEAK;
      default:   c = SS_OFF;
    endcase
    return c;
  endfunction

  function automatic logic timed_out(logic [TIME_BITS-1:0] now, logic [TIME_BITS-1:0] t,
                                     logic [CFG_W-1:0] lim);
    logic [TIME_BITS-1:0] d;
    d = now - t;
    return d >= TIME_BITS'(lim);
  endfunction

  // item with all side fields at zero
  function automatic act_t act_mk(act_code_t a);
    act_t r;
    r.action = a;
    r.eyes   = EYES_LISTEN;
    r.speech = SP_REPLY;
    r.attach = 1'b0;
    return r;
  endfunction

  function automatic work_t wk_push(work_t w, act_t a);
    work_t r;
    r = w;
    if (w.l.cnt < CNT_W'(MAX_ACTIONS)) begin
      r.l.item[w.l.cnt[IDX_W-1:0]] = a;
      r.l.cnt = w.l.cnt + CNT_W'(1);
    end
    return r;
  endfunction

  function automatic work_t wk_eyes(work_t w, eyes_t e);
    act_t a;
    a = act_mk(A_EYES);
    a.eyes = e;
    return wk_push(w, a);
  endfunction

  function automatic work_t wk_enter(work_t w, st_t st, logic [TIME_BITS-1:0] now);
    work_t r;
    r = w;
    r.s.mode     = st;
    r.s.entered  = now;
    r.s.end_sent = '0;
    r.s.started  = 1'b0;
    r.s.end_req  = 1'b0;
    return r;
  endfunction

  function automatic work_t wk_forget(work_t w);
    work_t r;
    r = w;
    if (w.s.appr) begin
      r.s.appr = 1'b0;
      r = wk_push(r, act_mk(A_FORGET));
    end
    return r;
  endfunction

  function automatic work_t wk_start_listen(work_t w, logic [TIME_BITS-1:0] now, logic att);
    work_t r;
    act_t  a;
    r = wk_forget(w);
    r = wk_enter(r, ST_LISTEN, now);
    r = wk_eyes(r, EYES_LISTEN);
    a = act_mk(A_ASR_START);
    a.attach = att;
    return wk_push(r, a);
  endfunction

  function automatic work_t wk_speak(work_t w, logic [TIME_BITS-1:0] now, speech_t sp);
    work_t r;
    act_t  a;
    r = wk_enter(w, ST_SPEAK, now);
    if (sp == SP_REPLY || sp == SP_TEXT || sp == SP_APPROVAL) begin
      r = wk_eyes(r, EYES_SPEAK);
    end
    a = act_mk(A_SPEAK);
    a.speech = sp;
    return wk_push(r, a);
  endfunction

  function automatic work_t wk_rest(work_t w, logic [TIME_BITS-1:0] now);
    work_t r;
    r = wk_enter(w, ST_IDLE, now);
    return wk_eyes(r, EYES_RESTORE);
  endfunction

  function automatic work_t wk_abandon(work_t w);
    work_t r;
    case (w.s.mode)
      ST_LISTEN: r = wk_push(w, act_mk(A_ASR_CANCEL));
      ST_THINK:  r = wk_push(w, act_mk(A_AGENT_CANCEL));
      ST_SPEAK:  r = wk_push(w, act_mk(A_SPEAK_CANCEL));
      default:   r = w;
    endcase
    return r;
  endfunction

  // end request: deferred until the recognizer has started, sent once
  function automatic work_t wk_req_end(work_t w, logic [TIME_BITS-1:0] now);
    work_t r;
    r = w;
    if (w.s.end_sent == '0) begin
      if (!w.s.started) begin
        r.s.end_req = 1'b1;
      end else begin
        r.s.end_sent = (now != '0) ? now : TIME_BITS'(1);
        r = wk_push(r, act_mk(A_ASR_END));
      end
    end
    return r;
  endfunction

endpackage

// ===== design/voice_session_controller_unit.sv =====
// top level of the voice session controller: input register, session state, output stage
`timescale 1ns / 1ps
// Path: an accepted event is held in the input register, then evaluated and loaded into the
// output stage register once that stage has space; the remaining results of the same event
// follow one per cycle while out_tready is high. Throughput, while out_tready is high: one
// event per cycle for single-result events, otherwise limited by the output stage that sends
// one action per transaction. Reset (synchronous, active low): session off, timestamps and
// flags cleared, timeout registers back to their defaults, input and output stages empty.

module voice_session_controller_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [vsc_pkg::IN_DATA_W-1:0]     in_tdata,   // now_ms, heard_speech, silence_ms, ok, empty_req
  input  logic [vsc_pkg::MODE_W-1:0]        in_tuser,   // mode
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [vsc_pkg::OUT_DATA_W-1:0]    out_tdata,  // eyes, speech, attach, accepted, session_state
  output logic [vsc_pkg::ACT_W-1:0]         out_tuser,  // action
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [vsc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vsc_pkg::CFG_W-1:0]         cfg_data
);

  logic            in_vld_r;
  logic            in_vld_nxt;
  vsc_pkg::evt_t   evt_r;
  vsc_pkg::evt_t   evt_in;
  vsc_pkg::sess_t  sess_r;
  vsc_pkg::sess_t  sess_nxt;
  vsc_pkg::cfg_t   cfg_r;
  vsc_pkg::res_t   res;
  logic            space;
  logic            commit;
  logic            in_take;

  // unpack the input transaction
  assign evt_in.mode         = in_tuser;
  assign evt_in.now_ms       = in_tdata[vsc_pkg::TIME_BITS-1:0];
  assign evt_in.heard_speech = in_tdata[vsc_pkg::IN_HEARD_B];
  assign evt_in.silence_ms   = in_tdata[vsc_pkg::IN_SIL_LO +: vsc_pkg::SIL_W];
  assign evt_in.ok           = in_tdata[vsc_pkg::IN_OK_B];
  assign evt_in.empty_req    = in_tdata[vsc_pkg::IN_EMPTY_B];

  // input register hand-off
  assign commit    = in_vld_r && space;
  assign in_tready = !in_vld_r || commit;
  assign in_take   = in_tvalid && in_tready;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (commit) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      evt_r <= evt_in;
    end
  end

  // event evaluation
  vsc_eval u_eval (
    .cur (sess_r),
    .evt (evt_r),
    .cfg (cfg_r),
    .nxt (sess_nxt),
    .res (res)
  );

  // session state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sess_r.mode       <= vsc_pkg::ST_OFF;
      sess_r.entered    <= '0;
      sess_r.end_sent   <= '0;
      sess_r.pend_since <= '0;
      sess_r.started    <= 1'b0;
      sess_r.end_req    <= 1'b0;
      sess_r.appr       <= 1'b0;
    end else if (commit) begin
      sess_r <= sess_nxt;
    end
  end

  // timeout registers, writes beyond the list are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= vsc_pkg::CFG_RST;
    end else if (cfg_valid && cfg_ready &&
                 cfg_index < vsc_pkg::CFG_IDX_W'(vsc_pkg::NUM_REGS)) begin
      cfg_r[cfg_index[vsc_pkg::REG_SEL_W-1:0]] <= cfg_data;
    end
  end

  // result stage
  vsc_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (commit),
    .res        (res),
    .space      (space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== design/vsc_eval.sv =====
// next-state and action-list logic for one registered event
`timescale 1ns / 1ps

module vsc_eval (
  input  vsc_pkg::sess_t cur,
  input  vsc_pkg::evt_t  evt,
  input  vsc_pkg::cfg_t  cfg,
  output vsc_pkg::sess_t nxt,
  output vsc_pkg::res_t  res
);

  vsc_pkg::work_t             w;
  logic                       acc;
  logic [vsc_pkg::TIME_BITS-1:0] now;
  logic                       is_wake;
  logic                       good;

  assign now     = evt.now_ms;
  assign is_wake = (evt.mode == vsc_pkg::EV_WAKE);
  assign good    = evt.ok && !evt.empty_req;

  // event dispatch: global events first, then per-state handling
  always_comb begin
    w.s = cur;
    w.l = '0;
    acc = 1'b0;
    if (evt.mode == vsc_pkg::EV_DISABLE) begin
      acc = 1'b1;
      if (cur.mode != vsc_pkg::ST_OFF) begin
        w = vsc_pkg::wk_abandon(w);
        w = vsc_pkg::wk_forget(w);
        if (cur.mode != vsc_pkg::ST_IDLE) begin
          w = vsc_pkg::wk_eyes(w, vsc_pkg::EYES_RESTORE);
        end
        w = vsc_pkg::wk_enter(w, vsc_pkg::ST_OFF, now);
      end
    end else if (evt.mode == vsc_pkg::EV_ENABLE) begin
      acc = 1'b1;
      if (cur.mode == vsc_pkg::ST_OFF) begin
        w = vsc_pkg::wk_enter(w, vsc_pkg::ST_IDLE, now);
      end
    end else if (evt.mode == vsc_pkg::EV_CANCEL && cur.mode != vsc_pkg::ST_OFF) begin
      acc = 1'b1;
      w = vsc_pkg::wk_abandon(w);
      w = vsc_pkg::wk_forget(w);
      if (cur.mode != vsc_pkg::ST_IDLE) begin
        w = vsc_pkg::wk_rest(w, now);
      end
    end else begin
      case (cur.mode)
        // idle
        vsc_pkg::ST_IDLE: begin
          acc = 1'b1;
          case (evt.mode)
            vsc_pkg::EV_WAKE, vsc_pkg::EV_LISTEN: begin
              w = vsc_pkg::wk_start_listen(w, now, is_wake);
            end
            vsc_pkg::EV_SAY: begin
              w = vsc_pkg::wk_speak(w, now, vsc_pkg::SP_TEXT);
            end
            vsc_pkg::EV_REPLY: begin
              if (!cur.appr) begin
                acc = 1'b0;
              end else begin
                w.s.appr = 1'b0;
                if (good) begin
                  w = vsc_pkg::wk_speak(w, now, vsc_pkg::SP_REPLY);
                end
              end
            end
            vsc_pkg::EV_AGENT_FAILED: begin
              w.s.appr = 1'b0;
            end
            vsc_pkg::EV_TICK: begin
              if (cur.appr &&
                  vsc_pkg::timed_out(now, cur.pend_since, cfg[vsc_pkg::REG_APPROVAL])) begin
                w = vsc_pkg::wk_forget(w);
              end
            end
            vsc_pkg::EV_LINK_LOST: begin
              acc = 1'b1;
            end
            default: begin
              acc = 1'b0;
            end
          endcase
        end
        // listening
        vsc_pkg::ST_LISTEN: begin
          acc = 1'b1;
          case (evt.mode)
            vsc_pkg::EV_ASR_STARTED: begin
              w.s.started = 1'b1;
              w.s.entered = now;
              if (cur.end_req) begin
                w = vsc_pkg::wk_req_end(w, now);
              end
            end
            vsc_pkg::EV_ASR_FAILED: begin
              w = vsc_pkg::wk_speak(w, now, vsc_pkg::SP_ERROR);
            end
            vsc_pkg::EV_ASR_ENDPOINT: begin
              if (evt.heard_speech) begin
                w = vsc_pkg::wk_req_end(w, now);
              end
            end
            vsc_pkg::EV_ASR_FINISHED: begin
              if (!good) begin
                w = vsc_pkg::wk_speak(w, now, vsc_pkg::SP_NOT_HEARD);
              end else begin
                w = vsc_pkg::wk_enter(w, vsc_pkg::ST_THINK, now);
                w = vsc_pkg::wk_eyes(w, vsc_pkg::EYES_THINK);
                w = vsc_pkg::wk_push(w, vsc_pkg::act_mk(vsc_pkg::A_SUBMIT));
              end
            end
            vsc_pkg::EV_TICK: begin
              if (!cur.started) begin
                if (vsc_pkg::timed_out(now, cur.entered, cfg[vsc_pkg::REG_ASR_START])) begin
                  w = vsc_pkg::wk_push(w, vsc_pkg::act_mk(vsc_pkg::A_ASR_CANCEL));
                  w = vsc_pkg::wk_speak(w, now, vsc_pkg::SP_ERROR);
                end
              end else if (cur.end_sent != '0) begin
                if (vsc_pkg::timed_out(now, cur.end_sent, cfg[vsc_pkg::REG_ASR_FINISH])) begin
                  w = vsc_pkg::wk_push(w, vsc_pkg::act_mk(vsc_pkg::A_ASR_CANCEL));
                  w = vsc_pkg::wk_speak(w, now, vsc_pkg::SP_NOT_HEARD);
                end
              end else if ((evt.heard_speech &&
                            evt.silence_ms >= cfg[vsc_pkg::REG_TRAIL_SIL]) ||
                           (!evt.heard_speech &&
                            vsc_pkg::timed_out(now, cur.entered,
                                               cfg[vsc_pkg::REG_NO_SPEECH])) ||
                           vsc_pkg::timed_out(now, cur.entered,
                                              cfg[vsc_pkg::REG_MAX_LISTEN])) begin
                w = vsc_pkg::wk_req_end(w, now);
              end
            end
            vsc_pkg::EV_LINK_LOST: begin
              w = vsc_pkg::wk_rest(w, now);
            end
            vsc_pkg::EV_WAKE, vsc_pkg::EV_LISTEN: begin
              acc = 1'b1;
            end
            default: begin
              acc = 1'b0;
            end
          endcase
        end
        // thinking
        vsc_pkg::ST_THINK: begin
          acc = 1'b1;
          case (evt.mode)
            vsc_pkg::EV_REPLY: begin
              if (good) begin
                w = vsc_pkg::wk_speak(w, now, vsc_pkg::SP_REPLY);
              end else begin
                w = vsc_pkg::wk_speak(w, now, vsc_pkg::SP_ERROR);
              end
            end
            vsc_pkg::EV_PENDING: begin
              w.s.appr       = 1'b1;
              w.s.pend_since = now;
              w = vsc_pkg::wk_speak(w, now, vsc_pkg::SP_APPROVAL);
            end
            vsc_pkg::EV_BUSY: begin
              w = vsc_pkg::wk_speak(w, now, vsc_pkg::SP_BUSY);
            end
            vsc_pkg::EV_AGENT_FAILED: begin
              w = vsc_pkg::wk_speak(w, now, vsc_pkg::SP_ERROR);
            end
            vsc_pkg::EV_TICK: begin
              if (vsc_pkg::timed_out(now, cur.entered, cfg[vsc_pkg::REG_THINK])) begin
                w = vsc_pkg::wk_push(w, vsc_pkg::act_mk(vsc_pkg::A_AGENT_CANCEL));
                w = vsc_pkg::wk_speak(w, now, vsc_pkg::SP_ERROR);
              end
            end
            vsc_pkg::EV_WAKE, vsc_pkg::EV_LISTEN: begin
              w = vsc_pkg::wk_push(w, vsc_pkg::act_mk(vsc_pkg::A_AGENT_CANCEL));
              w = vsc_pkg::wk_start_listen(w, now, is_wake);
            end
            vsc_pkg::EV_LINK_LOST: begin
              acc = 1'b1;
            end
            default: begin
              acc = 1'b0;
            end
          endcase
        end
        // speaking
        vsc_pkg::ST_SPEAK: begin
          acc = 1'b1;
          case (evt.mode)
            vsc_pkg::EV_SPEAK_DONE: begin
              w = vsc_pkg::wk_rest(w, now);
            end
            vsc_pkg::EV_WAKE, vsc_pkg::EV_LISTEN: begin
              w = vsc_pkg::wk_push(w, vsc_pkg::act_mk(vsc_pkg::A_SPEAK_CANCEL));
              w = vsc_pkg::wk_start_listen(w, now, is_wake);
            end
            vsc_pkg::EV_LINK_LOST: begin
              w = vsc_pkg::wk_push(w, vsc_pkg::act_mk(vsc_pkg::A_SPEAK_CANCEL));
              w = vsc_pkg::wk_rest(w, now);
            end
            vsc_pkg::EV_TICK: begin
              if (vsc_pkg::timed_out(now, cur.entered, cfg[vsc_pkg::REG_SPEAK])) begin
                w = vsc_pkg::wk_push(w, vsc_pkg::act_mk(vsc_pkg::A_SPEAK_CANCEL));
                w = vsc_pkg::wk_rest(w, now);
              end
            end
            vsc_pkg::EV_REPLY, vsc_pkg::EV_AGENT_FAILED: begin
              w.s.appr = 1'b0;
            end
            default: begin
              acc = 1'b0;
            end
          endcase
        end
        default: begin
          acc = 1'b0;
        end
      endcase
    end
    // an event with no actions still reports one item
    if (w.l.cnt == '0) begin
      w = vsc_pkg::wk_push(w, vsc_pkg::act_mk(vsc_pkg::A_NONE));
    end
  end

  assign nxt          = w.s;
  assign res.lst      = w.l;
  assign res.accepted = acc;
  assign res.ss       = vsc_pkg::st_code(w.s.mode);

endmodule

// ===== design/vsc_emit.sv =====
// output stage: holds one event's action list and sends it one item per transaction
`timescale 1ns / 1ps

module vsc_emit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              load,
  input  vsc_pkg::res_t                     res,
  output logic                              space,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [vsc_pkg::OUT_DATA_W-1:0]    out_tdata,  // eyes, speech, attach, accepted, session_state
  output logic [vsc_pkg::ACT_W-1:0]         out_tuser,  // action
  output logic                              out_tlast
);

  logic                        vld_r;
  logic                        vld_nxt;
  logic [vsc_pkg::IDX_W-1:0]   idx_r;
  logic [vsc_pkg::IDX_W-1:0]   idx_nxt;
  vsc_pkg::res_t               res_r;
  vsc_pkg::act_t               item;
  logic                        last;
  logic                        take;

  // current item and end of list
  assign item  = res_r.lst.item[idx_r];
  assign last  = (vsc_pkg::CNT_W'(idx_r) + vsc_pkg::CNT_W'(1)) == res_r.lst.cnt;
  assign take  = vld_r && out_tready;
  assign space = !vld_r || (take && last);

  // list pointer and valid
  always_comb begin
    vld_nxt = vld_r;
    idx_nxt = idx_r;
    if (load) begin
      vld_nxt = 1'b1;
      idx_nxt = '0;
    end else if (take) begin
      if (last) begin
        vld_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + vsc_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      idx_r <= idx_nxt;
    end
  end

  // list payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tuser  = item.action;
  assign out_tlast  = last;
  assign out_tdata  = {(vsc_pkg::OUT_DATA_W - vsc_pkg::OUT_USED_W)'(0),
                       res_r.ss, res_r.accepted, item.attach, item.speech, item.eyes};

endmodule

// ===== design/vsc_chk.sv =====
// port-level checks for the voice session controller, bound to the top level
`timescale 1ns / 1ps

module vsc_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [vsc_pkg::IN_DATA_W-1:0]     in_tdata,
  input logic [vsc_pkg::MODE_W-1:0]        in_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [vsc_pkg::OUT_DATA_W-1:0]    out_tdata,
  input logic [vsc_pkg::ACT_W-1:0]         out_tuser,
  input logic                              out_tlast,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic [vsc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input logic [vsc_pkg::CFG_W-1:0]         cfg_data
);

  // a stalled result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("result changed while stalled");

  // a none item is always the only one of its event
  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == vsc_pkg::A_NONE |-> out_tlast)
    else $error("none item not marked last");

  // a rejected event gives a single none item
  a_reject_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[6] |-> out_tuser == vsc_pkg::A_NONE && out_tlast)
    else $error("rejected event produced actions");

  // reported state is one of the five session states
  a_state_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[9:7] <= vsc_pkg::SS_SPEAK)
    else $error("session state out of range");

  // nothing is offered straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind voice_session_controller_unit vsc_chk u_vsc_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready),
  .cfg_index  (cfg_index),
  .cfg_data   (cfg_data)
);
